[hdl/nmea_sentence_validator_defines.svh]
// Assertion macros shared by the validator modules.
`ifndef NMEA_SENTENCE_VALIDATOR_DEFINES_SVH
`define NMEA_SENTENCE_VALIDATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define NMV_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define NMV_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define NMV_ASSERT(lbl, clk, rst, prop, msg)

`define NMV_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

[hdl/nmv_pkg.sv]
package nmv_pkg;

  localparam int MAX_LINE   = 120;
  localparam int COUNT_W    = $clog2(MAX_LINE + 1);
  localparam int CNT_OUT_W  = 7;
  localparam int CNT_SAT    = 127;
  localparam int TAIL_DEPTH = 5;
  localparam int ID_INDEX   = 5;
  localparam int MIN_KEPT   = 6;
  localparam int MAX_SHORT  = 6;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_FRAMING  = 2'd2,
    STATUS_CHECKSUM = 2'd3
  } nmv_status_t;

  typedef struct packed {
    nmv_status_t            status;
    logic [7:0]             sentence_id;
    logic [CNT_OUT_W-1:0]   kept_length;
    logic [CNT_OUT_W-1:0]   removed_count;
  } nmv_result_t;

  typedef struct packed {
    logic bad;
    logic [3:0] value;
  } nmv_hex_t;

  function automatic nmv_hex_t hex_value(input logic [7:0] c);
    nmv_hex_t h;
    h.bad = 1'b0;
    h.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = 4'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.value = 4'(c - 8'h41 + 8'd10);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.value = 4'(c - 8'h61 + 8'd10);
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

  function automatic logic [CNT_OUT_W-1:0] sat_count(input logic [COUNT_W-1:0] v);
    if (COUNT_W > CNT_OUT_W && v > COUNT_W'(CNT_SAT)) begin
      return CNT_OUT_W'(CNT_SAT);
    end
    return CNT_OUT_W'(v);
  endfunction

endpackage

[hdl/nmv_line_tracker.sv]
`include "nmea_sentence_validator_defines.svh"

module nmv_line_tracker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  output logic                 line_done,
  output nmv_pkg::nmv_result_t result
);

  logic [nmv_pkg::COUNT_W-1:0] raw_count;
  logic [nmv_pkg::COUNT_W-1:0] kept_count;
  logic [nmv_pkg::COUNT_W-1:0] removed_total;
  logic                        last_was_cr;
  logic [7:0]                  xor_accumulator;
  logic [7:0]                  tail_history [nmv_pkg::TAIL_DEPTH];
  logic [7:0]                  first_kept_byte;
  logic [7:0]                  id_byte;

  logic [nmv_pkg::COUNT_W-1:0] raw_count_next;
  logic [nmv_pkg::COUNT_W-1:0] kept_count_next;
  logic [nmv_pkg::COUNT_W-1:0] removed_total_next;
  logic [7:0]                  xor_accumulator_next;
  logic [7:0]                  tail_history_next [nmv_pkg::TAIL_DEPTH];
  logic [7:0]                  first_kept_byte_next;
  logic [7:0]                  id_byte_next;
  logic                        keep;
  nmv_pkg::nmv_hex_t           hex_hi;
  nmv_pkg::nmv_hex_t           hex_lo;

  always_comb begin
    keep = (data_byte inside {[nmv_pkg::PRINT_LO:nmv_pkg::PRINT_HI]}) ||
           data_byte == nmv_pkg::CH_CR || data_byte == nmv_pkg::CH_LF;
    raw_count_next = raw_count + 1'b1;
    kept_count_next = keep ? kept_count + 1'b1 : kept_count;
    removed_total_next = keep ? removed_total : removed_total + 1'b1;
    xor_accumulator_next = xor_accumulator;
    if (keep && kept_count >= nmv_pkg::COUNT_W'(nmv_pkg::MIN_KEPT)) begin
      xor_accumulator_next = xor_accumulator ^ tail_history[0];
    end
    for (int i = 0; i < nmv_pkg::TAIL_DEPTH; i++) begin
      tail_history_next[i] = tail_history[i];
    end
    if (keep) begin
      for (int i = 0; i < nmv_pkg::TAIL_DEPTH - 1; i++) begin
        tail_history_next[i] = tail_history[i + 1];
      end
      tail_history_next[nmv_pkg::TAIL_DEPTH-1] = data_byte;
    end
    first_kept_byte_next = (keep && kept_count == '0) ? data_byte : first_kept_byte;
    id_byte_next = (keep && kept_count == nmv_pkg::COUNT_W'(nmv_pkg::ID_INDEX)) ?
                   data_byte : id_byte;

    line_done = (last_was_cr && data_byte == nmv_pkg::CH_LF) ||
                raw_count_next >= nmv_pkg::COUNT_W'(nmv_pkg::MAX_LINE);

    hex_hi = nmv_pkg::hex_value(tail_history_next[1]);
    hex_lo = nmv_pkg::hex_value(tail_history_next[2]);
    if (raw_count_next <= nmv_pkg::COUNT_W'(nmv_pkg::MAX_SHORT)) begin
      result.status = nmv_pkg::STATUS_SHORT;
    end else if (kept_count_next < nmv_pkg::COUNT_W'(nmv_pkg::MIN_KEPT)) begin
      result.status = nmv_pkg::STATUS_FRAMING;
    end else if (first_kept_byte_next != nmv_pkg::CH_START ||
                 tail_history_next[0] != nmv_pkg::CH_STAR) begin
      result.status = nmv_pkg::STATUS_FRAMING;
    end else if (hex_hi.bad || hex_lo.bad ||
                 xor_accumulator_next != {hex_hi.value, hex_lo.value}) begin
      result.status = nmv_pkg::STATUS_CHECKSUM;
    end else begin
      result.status = nmv_pkg::STATUS_OK;
    end
    result.sentence_id = (kept_count_next > nmv_pkg::COUNT_W'(nmv_pkg::ID_INDEX)) ?
                         id_byte_next : 8'd0;
    result.kept_length = nmv_pkg::sat_count(kept_count_next);
    result.removed_count = nmv_pkg::sat_count(removed_total_next);
  end

  always_ff @(posedge clk) begin
    if (rst || (step && line_done)) begin
      raw_count <= '0;
      kept_count <= '0;
      removed_total <= '0;
      last_was_cr <= 1'b0;
      xor_accumulator <= '0;
      for (int i = 0; i < nmv_pkg::TAIL_DEPTH; i++) begin
        tail_history[i] <= '0;
      end
      first_kept_byte <= '0;
      id_byte <= '0;
    end else if (step) begin
      raw_count <= raw_count_next;
      kept_count <= kept_count_next;
      removed_total <= removed_total_next;
      last_was_cr <= (data_byte == nmv_pkg::CH_CR);
      xor_accumulator <= xor_accumulator_next;
      for (int i = 0; i < nmv_pkg::TAIL_DEPTH; i++) begin
        tail_history[i] <= tail_history_next[i];
      end
      first_kept_byte <= first_kept_byte_next;
      id_byte <= id_byte_next;
    end
  end

  `NMV_ASSERT(a_counts_add_up, clk, rst, ({1'b0, kept_count} + {1'b0, removed_total}) == {1'b0, raw_count}, "kept and removed counts do not add up to raw count")
  `NMV_ASSERT(a_raw_below_max, clk, rst, raw_count < nmv_pkg::COUNT_W'(nmv_pkg::MAX_LINE), "raw count reached line limit without ending line")
  `NMV_NEVER(a_cr_needs_byte, clk, rst, last_was_cr && raw_count == '0, "CR flag set on empty line")

endmodule

[hdl/nmea_sentence_validator.sv]
// A line-ending byte passes through the byte register, then the result register.
// Throughput: one byte per cycle; a line-ending byte waits only while the previous line
// result is still held in the output register.
// Reset: synchronous, clears the line counters, history and the valid flags of the byte
// and result registers; the block is ready once reset is released.
`include "nmea_sentence_validator_defines.svh"

module nmea_sentence_validator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            byte_valid,
  output logic                            byte_ready,
  input  logic [7:0]                      data_byte,
  output logic                            line_valid,
  input  logic                            line_ready,
  output logic [1:0]                      status,
  output logic [7:0]                      sentence_id,
  output logic [nmv_pkg::CNT_OUT_W-1:0]   kept_length,
  output logic [nmv_pkg::CNT_OUT_W-1:0]   removed_count
);

  logic                 byte_held;
  logic [7:0]           byte_reg;
  logic                 advance;
  logic                 line_done;
  nmv_pkg::nmv_result_t line_result;
  nmv_pkg::nmv_result_t result_reg;

  nmv_line_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (byte_reg),
    .line_done (line_done),
    .result    (line_result)
  );

  assign advance    = byte_held && (!line_done || !line_valid || line_ready);
  assign byte_ready = !byte_held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_held <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      byte_held <= 1'b1;
    end else if (advance) begin
      byte_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      byte_reg <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= 1'b0;
    end else if (advance && line_done) begin
      line_valid <= 1'b1;
    end else if (line_ready) begin
      line_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && line_done) begin
      result_reg <= line_result;
    end
  end

  assign status        = result_reg.status;
  assign sentence_id   = result_reg.sentence_id;
  assign kept_length   = result_reg.kept_length;
  assign removed_count = result_reg.removed_count;

  `NMV_NEVER(a_no_overwrite, clk, rst, advance && line_done && line_valid && !line_ready, "line result overwritten before transaction")
  `NMV_ASSERT(a_plain_byte_flows, clk, rst, byte_held && !line_done |-> byte_ready, "byte that ends no line stalled input")
  `NMV_ASSERT(a_result_loaded, clk, rst, advance && line_done |=> line_valid, "finished line produced no result")

endmodule
